[rtl/fpps_pkg.sv]
`timescale 1ns / 1ps
package fpps_pkg;

	localparam int unsigned QW = 32;
	localparam int unsigned DtW = 31;
	localparam logic [DtW-1:0] DefaultStep = 31'd655;
	localparam logic signed [QW-1:0] QMax = 32'sh7fff_ffff;
	localparam logic signed [QW-1:0] QMin = 32'sh8000_0000;
	localparam logic signed [QW-1:0] QHalf = 32'sh0000_8000;
	localparam logic signed [QW-1:0] QTwo = 32'sh0002_0000;

	localparam int unsigned NumRegs = 8;
	localparam int unsigned AddrW = 5;

	typedef enum logic [2:0] {
		REG_GAIN_P = 3'd0,
		REG_GAIN_I = 3'd1,
		REG_GAIN_D = 3'd2,
		REG_TAU = 3'd3,
		REG_OUT_LO = 3'd4,
		REG_OUT_HI = 3'd5,
		REG_INT_LO = 3'd6,
		REG_INT_HI = 3'd7
	} reg_idx_t;

	function automatic logic signed [QW-1:0] sat33(input logic signed [QW:0] s);
		logic signed [QW-1:0] r;
		if (s[QW] != s[QW-1]) begin
			r = s[QW] ? QMin : QMax;
		end else begin
			r = s[QW-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [QW-1:0] qadd(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [QW:0] s;
		s = {a[QW-1], a} + {b[QW-1], b};
		return sat33(s);
	endfunction

	function automatic logic signed [QW-1:0] qsub(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [QW:0] s;
		s = {a[QW-1], a} - {b[QW-1], b};
		return sat33(s);
	endfunction

	function automatic logic signed [QW-1:0] qclamp(input logic signed [QW-1:0] x,
			input logic signed [QW-1:0] lo, input logic signed [QW-1:0] hi);
		logic signed [QW-1:0] r;
		r = x;
		if (r < lo) begin
			r = lo;
		end
		if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

[rtl/fpps_mul.sv]
`timescale 1ns / 1ps
module fpps_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [fpps_pkg::QW-1:0] a,
	input logic signed [fpps_pkg::QW-1:0] b,
	output logic done,
	output logic signed [fpps_pkg::QW-1:0] result
);

	localparam int unsigned W = fpps_pkg::QW;

	logic busy_q;
	logic [5:0] cnt_q;
	logic signed [W:0] acc_q;
	logic [W-1:0] lo_q;
	logic signed [W-1:0] a_q;
	logic signed [W:0] addend;
	logic signed [W:0] sum;
	logic [2*W-1:0] prod;
	logic signed [48:0] qv;
	logic last_bit;
	logic finish;

	assign last_bit = (cnt_q == 6'(W - 1));
	assign finish = busy_q && (cnt_q == 6'(W));
	assign addend = lo_q[0] ? {a_q[W-1], a_q} : '0;
	assign sum = last_bit ? (acc_q - addend) : (acc_q + addend);
	assign prod = {acc_q[W-1:0], lo_q};
	assign qv = $signed({prod[2*W-1], prod[2*W-1:16]}) + $signed({48'd0, prod[15]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
				done <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			lo_q <= b;
			a_q <= a;
		end else if (busy_q && !finish) begin
			acc_q <= {sum[W], sum[W:1]};
			lo_q <= {sum[0], lo_q[W-1:1]};
		end
		if (finish) begin
			if (qv > $signed({{17{1'b0}}, fpps_pkg::QMax})) begin
				result <= fpps_pkg::QMax;
			end else if (qv < $signed({{17{1'b1}}, fpps_pkg::QMin})) begin
				result <= fpps_pkg::QMin;
			end else begin
				result <= qv[W-1:0];
			end
		end
	end

endmodule

[rtl/fpps_div.sv]
`timescale 1ns / 1ps
module fpps_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [fpps_pkg::QW-1:0] a,
	input logic signed [fpps_pkg::QW-1:0] b,
	output logic done,
	output logic signed [fpps_pkg::QW-1:0] result
);

	localparam int unsigned W = fpps_pkg::QW;
	localparam int unsigned NW = W + 17;

	logic busy_q;
	logic [5:0] cnt_q;
	logic [NW-1:0] n_q;
	logic [W:0] rem_q;
	logic [W:0] d_q;
	logic neg_q;
	logic zero_q;
	logic [W-1:0] ua;
	logic [W-1:0] ub;
	logic [W+1:0] r2;
	logic [W+1:0] diff;
	logic qbit;
	logic finish;

	assign ua = a[W-1] ? W'(-a) : W'(a);
	assign ub = b[W-1] ? W'(-b) : W'(b);
	assign r2 = {rem_q, n_q[NW-1]};
	assign diff = r2 - {1'b0, d_q};
	assign qbit = !diff[W+1];
	assign finish = busy_q && (cnt_q == 6'(NW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
				done <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= {ua, 17'd0} + {17'd0, ub};
			d_q <= {ub, 1'b0};
			rem_q <= '0;
			neg_q <= a[W-1] ^ b[W-1];
			zero_q <= (b == '0);
		end else if (busy_q && !finish) begin
			rem_q <= qbit ? diff[W:0] : r2[W:0];
			n_q <= {n_q[NW-2:0], qbit};
		end
		if (finish) begin
			if (zero_q) begin
				result <= fpps_pkg::QMin;
			end else if (neg_q) begin
				if (n_q > NW'(33'h0_8000_0000)) begin
					result <= fpps_pkg::QMin;
				end else begin
					result <= W'(-n_q);
				end
			end else if (n_q > NW'(32'h7fff_ffff)) begin
				result <= fpps_pkg::QMax;
			end else begin
				result <= n_q[W-1:0];
			end
		end
	end

endmodule

[rtl/fixed_point_pid_step.sv]
`timescale 1ns / 1ps
// With the derivative enabled a request runs eight serial multiplies and one serial divide;
// when gain_d is zero only the proportional and integral multiplies run and the divide is skipped.
// No new request is taken until the current one has left the output state; the bit-serial
// multiplier is shared by every multiply step, and the output state waits while a result is unread.
// A finished result is held in the output register while the next request is taken.
// Reset clears the FSM, integrator and history, zeroes gains and tau, sets limits to QMin/QMax.
module fixed_point_pid_step #(
	parameter logic [fpps_pkg::DtW-1:0] DEFAULT_STEP = fpps_pkg::DefaultStep
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [fpps_pkg::AddrW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] target,
	input logic signed [31:0] sensed,
	input logic [30:0] step_time,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] drive
);

	localparam int unsigned W = fpps_pkg::QW;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_PROP = 11'b000_0000_0010,
		ST_T1 = 11'b000_0000_0100,
		ST_T2 = 11'b000_0000_1000,
		ST_T3 = 11'b000_0001_0000,
		ST_TT = 11'b000_0010_0000,
		ST_GA = 11'b000_0100_0000,
		ST_GC = 11'b000_1000_0000,
		ST_GE = 11'b001_0000_0000,
		ST_DIV = 11'b010_0000_0000,
		ST_OUT = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	logic issued_q;

	logic signed [W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [30:0] tau_q;
	logic signed [W-1:0] out_lo_q, out_hi_q, int_lo_q, int_hi_q;

	logic signed [W-1:0] integ_q, last_err_q, deriv_q, last_sensed_q;
	logic signed [W-1:0] sensed_q, err_q, prop_q, t1_q, t2_q, tt_q, tmp_q;
	logic [30:0] dt_q;

	logic signed [W-1:0] mul_a, mul_b, mul_res, div_res, dt_s;
	logic mul_go, mul_start, mul_done, div_start, div_done, wr;
	logic [2:0] widx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign widx = paddr[4:2];
	assign dt_s = $signed({1'b0, dt_q});

	always_comb begin
		unique case (fpps_pkg::reg_idx_t'(widx))
			fpps_pkg::REG_GAIN_P: prdata = gain_p_q;
			fpps_pkg::REG_GAIN_I: prdata = gain_i_q;
			fpps_pkg::REG_GAIN_D: prdata = gain_d_q;
			fpps_pkg::REG_TAU: prdata = {1'b0, tau_q};
			fpps_pkg::REG_OUT_LO: prdata = out_lo_q;
			fpps_pkg::REG_OUT_HI: prdata = out_hi_q;
			fpps_pkg::REG_INT_LO: prdata = int_lo_q;
			fpps_pkg::REG_INT_HI: prdata = int_hi_q;
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			tau_q <= '0;
			out_lo_q <= fpps_pkg::QMin;
			out_hi_q <= fpps_pkg::QMax;
			int_lo_q <= fpps_pkg::QMin;
			int_hi_q <= fpps_pkg::QMax;
		end else if (wr) begin
			unique case (fpps_pkg::reg_idx_t'(widx))
				fpps_pkg::REG_GAIN_P: gain_p_q <= pwdata;
				fpps_pkg::REG_GAIN_I: gain_i_q <= pwdata;
				fpps_pkg::REG_GAIN_D: gain_d_q <= pwdata;
				fpps_pkg::REG_TAU: tau_q <= pwdata[30:0];
				fpps_pkg::REG_OUT_LO: out_lo_q <= pwdata;
				fpps_pkg::REG_OUT_HI: out_hi_q <= pwdata;
				fpps_pkg::REG_INT_LO: int_lo_q <= pwdata;
				fpps_pkg::REG_INT_HI: int_hi_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		mul_go = 1'b1;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_PROP: begin
				mul_a = gain_p_q;
				mul_b = err_q;
			end
			ST_T1: begin
				mul_a = fpps_pkg::QHalf;
				mul_b = gain_i_q;
			end
			ST_T2: begin
				mul_a = dt_s;
				mul_b = err_q + last_err_q;
			end
			ST_T3: begin
				mul_a = t1_q;
				mul_b = t2_q;
			end
			ST_TT: begin
				mul_a = fpps_pkg::QTwo;
				mul_b = $signed({1'b0, tau_q});
			end
			ST_GA: begin
				mul_a = fpps_pkg::QTwo;
				mul_b = gain_d_q;
			end
			ST_GC: begin
				mul_a = tmp_q;
				mul_b = fpps_pkg::qsub(sensed_q, last_sensed_q);
			end
			ST_GE: begin
				mul_a = fpps_pkg::qsub(tt_q, dt_s);
				mul_b = deriv_q;
			end
			default: mul_go = 1'b0;
		endcase
	end

	assign mul_start = mul_go && !issued_q;
	assign div_start = (state_q == ST_DIV) && !issued_q;
	assign in_ready = (state_q == ST_IDLE);

	fpps_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.done(mul_done),
		.result(mul_res)
	);

	fpps_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.a(fpps_pkg::qadd(tmp_q, t2_q)),
		.b(fpps_pkg::qadd(tt_q, dt_s)),
		.done(div_done),
		.result(div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			out_valid <= 1'b0;
			integ_q <= '0;
			last_err_q <= '0;
			deriv_q <= '0;
			last_sensed_q <= '0;
		end else begin
			if (out_valid && out_ready && (state_q != ST_OUT)) begin
				out_valid <= 1'b0;
			end
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end
			if (mul_done || div_done) begin
				issued_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PROP;
					end
				end
				ST_PROP: if (mul_done) state_q <= ST_T1;
				ST_T1: if (mul_done) state_q <= ST_T2;
				ST_T2: if (mul_done) state_q <= ST_T3;
				ST_T3: begin
					if (mul_done) begin
						integ_q <= fpps_pkg::qclamp(fpps_pkg::qadd(integ_q, mul_res),
							int_lo_q, int_hi_q);
						if (gain_d_q == '0) begin
							deriv_q <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_TT;
						end
					end
				end
				ST_TT: if (mul_done) state_q <= ST_GA;
				ST_GA: if (mul_done) state_q <= ST_GC;
				ST_GC: if (mul_done) state_q <= ST_GE;
				ST_GE: if (mul_done) state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						deriv_q <= div_res;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						last_err_q <= err_q;
						last_sensed_q <= sensed_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sensed_q <= sensed;
			err_q <= fpps_pkg::qsub(target, sensed);
			dt_q <= (step_time == '0) ? DEFAULT_STEP : step_time;
		end
		if (mul_done) begin
			unique case (state_q)
				ST_PROP: prop_q <= mul_res;
				ST_T1: t1_q <= mul_res;
				ST_T2: t2_q <= mul_res;
				ST_TT: tt_q <= mul_res;
				ST_GA: tmp_q <= mul_res;
				ST_GC: tmp_q <= mul_res;
				ST_GE: t2_q <= mul_res;
				default: ;
			endcase
		end
		if ((state_q == ST_OUT) && (!out_valid || out_ready)) begin
			drive <= fpps_pkg::qclamp(fpps_pkg::qadd(fpps_pkg::qadd(prop_q, integ_q), deriv_q),
				out_lo_q, out_hi_q);
		end
	end

	a_div_only_with_gain: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (gain_d_q != '0))
		else $error("divide started with derivative disabled");

	a_mul_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |=> !mul_done)
		else $error("multiplier done held for more than one cycle");

	a_no_start_while_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |=> !mul_start)
		else $error("multiplier restarted while busy");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while a step is running");

endmodule
